/* design/ichm_pkg.sv */
// shared constants and types for the indexed chain hash map
package ichm_pkg;
	localparam int NumSlots = 1024;
	localparam int NumBuckets = 1024;
	localparam int SlotW = $clog2(NumSlots);
	localparam int BucketW = $clog2(NumBuckets);
	localparam int LinkW = SlotW + 2;
	localparam logic [LinkW-1:0] LINK_END = LinkW'(NumSlots);
	localparam logic [LinkW-1:0] LINK_FREE = LinkW'(NumSlots + 1);
	localparam int KeyW = 64 + 34 + 32;

	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_CORRUPT = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [KeyW-1:0] key;
		logic [BucketW-1:0] bucket;
		logic [SlotW-1:0] slot_index;
	} req_t;

	typedef struct packed {
		logic found;
		logic [SlotW-1:0] match_slot;
		logic [1:0] status;
	} rsp_t;
endpackage

/* design/indexed_chain_hash_map_unit.sv */
// indexed chain hash map top level: sequencer walking bucket chains in memory
// steps: read the bucket head, then walk the chain comparing one entry at a time; an insert miss
// checks its slot and links it in at the head, a delete unlinks the hit at the head or rewrites
// its predecessor's link, a reject skips the walk. throughput: one request at a time; the next
// word is taken the cycle after the result is registered; a full output register stalls the finish
// reset: async low; then a clearing pass writes every bucket head and slot entry
module indexed_chain_hash_map_unit (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// req_type, space_oid, database_oid, relation_number, fork_number,
	// block_number, hash_code, slot_index, zero pad
	input logic [175:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// found, match_slot, status, zero pad
	output logic [15:0] m_tdata
);
	import ichm_pkg::*;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_HEAD = 4'd2;
	localparam logic [3:0] S_WALK = 4'd3;
	localparam logic [3:0] S_CMP = 4'd4;
	localparam logic [3:0] S_CHK = 4'd5;
	localparam logic [3:0] S_UPD = 4'd6;
	localparam logic [3:0] S_UPD2 = 4'd7;
	localparam logic [3:0] S_FIX = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [3:0] state_q;
	logic [SlotW:0] clr_q;
	req_t req_q;
	rsp_t rsp_q;
	rsp_t out_rsp_q;
	logic out_v_q;
	logic [LinkW-1:0] prev_q, cur_q, succ_q;
	logic [SlotW:0] steps_q;

	logic h_rd, h_we, s_rd, s_we;
	logic [BucketW-1:0] h_ra, h_wa;
	logic [LinkW-1:0] h_rdat, h_wd, s_rlink, s_wlink;
	logic [SlotW-1:0] s_ra, s_wa;
	logic [KeyW-1:0] s_rkey, s_wkey;

	ichm_head_mem u_head (.clk, .rd_en(h_rd), .rd_addr(h_ra), .rd_data(h_rdat),
		.wr_en(h_we), .wr_addr(h_wa), .wr_data(h_wd));
	ichm_slot_mem u_slot (.clk, .rd_en(s_rd), .rd_addr(s_ra), .rd_key(s_rkey),
		.rd_link(s_rlink), .wr_en(s_we), .wr_addr(s_wa), .wr_key(s_wkey),
		.wr_link(s_wlink));

	req_t in_req;
	always_comb begin
		in_req.req_type = s_tdata[1:0];
		in_req.key = s_tdata[131:2];
		in_req.bucket = s_tdata[132+BucketW-1:132];
		in_req.slot_index = s_tdata[173:164];
	end
	logic in_blk_bad;
	assign in_blk_bad = s_tdata[131:100] == 32'hFFFFFFFF;

	logic out_load;
	assign out_load = state_q == S_DONE && (!out_v_q || m_tready);

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = out_v_q;
	assign m_tdata = {3'd0, out_rsp_q.status, out_rsp_q.match_slot, out_rsp_q.found};

	logic cur_is_slot, key_hit;
	assign cur_is_slot = cur_q < LINK_END;
	assign key_hit = s_rkey == req_q.key;

	always_comb begin
		h_rd = 1'b0; h_ra = req_q.bucket;
		h_we = 1'b0; h_wa = req_q.bucket; h_wd = LINK_END;
		s_rd = 1'b0; s_ra = cur_q[SlotW-1:0];
		s_we = 1'b0; s_wa = cur_q[SlotW-1:0]; s_wkey = '0; s_wlink = LINK_FREE;
		case (state_q)
			S_CLEAR: begin
				h_we = 1'b1; h_wa = clr_q[BucketW-1:0];
				s_we = 1'b1; s_wa = clr_q[SlotW-1:0];
			end
			S_IDLE: begin
				h_rd = s_tvalid && s_tready; h_ra = in_req.bucket;
			end
			S_WALK: begin
				s_rd = cur_is_slot && steps_q < (SlotW+1)'(NumSlots);
			end
			S_CHK: begin
				s_rd = 1'b1; s_ra = req_q.slot_index;
			end
			S_UPD: begin
				if (req_q.req_type == REQ_DELETE) begin
					s_we = 1'b1;
					if (prev_q == LINK_END) begin
						h_we = 1'b1; h_wd = succ_q;
					end
				end else if (s_rlink == LINK_FREE) begin
					s_we = 1'b1; s_wa = req_q.slot_index; s_wkey = req_q.key;
					s_wlink = h_rdat;
					h_we = 1'b1; h_wd = LinkW'(req_q.slot_index);
				end
			end
			S_UPD2: begin
				s_rd = 1'b1; s_ra = prev_q[SlotW-1:0];
			end
			S_FIX: begin
				s_we = 1'b1; s_wa = prev_q[SlotW-1:0]; s_wkey = s_rkey; s_wlink = succ_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			out_v_q <= 1'b0;
			out_rsp_q <= '0;
			req_q <= '0;
			rsp_q <= '0;
			prev_q <= LINK_END;
			cur_q <= LINK_END;
			succ_q <= LINK_FREE;
			steps_q <= '0;
		end else begin
			out_v_q <= out_load || (out_v_q && !m_tready);
			if (out_load) out_rsp_q <= rsp_q;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (SlotW+1)'(NumSlots - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						req_q <= in_req;
						rsp_q.found <= 1'b0;
						rsp_q.match_slot <= '0;
						prev_q <= LINK_END;
						steps_q <= '0;
						if (in_req.req_type == REQ_INSERT && in_blk_bad) begin
							rsp_q.status <= ST_REJECT;
							state_q <= S_DONE;
						end else begin
							rsp_q.status <= ST_OK;
							state_q <= S_HEAD;
						end
					end
				end
				S_HEAD: begin
					cur_q <= h_rdat;
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (s_rd) state_q <= S_CMP;
					else if (req_q.req_type == REQ_INSERT) state_q <= S_CHK;
					else begin
						rsp_q.status <= req_q.req_type == REQ_DELETE ? ST_CORRUPT : ST_OK;
						state_q <= S_DONE;
					end
				end
				S_CMP: begin
					if (key_hit) begin
						rsp_q.found <= 1'b1;
						rsp_q.match_slot <= cur_q[SlotW-1:0];
						succ_q <= s_rlink;
						state_q <= req_q.req_type == REQ_DELETE ? S_UPD : S_DONE;
					end else begin
						prev_q <= cur_q;
						cur_q <= s_rlink;
						steps_q <= steps_q + 1'b1;
						state_q <= S_WALK;
					end
				end
				S_CHK: state_q <= S_UPD;
				S_UPD: begin
					if (req_q.req_type == REQ_DELETE) begin
						state_q <= prev_q == LINK_END ? S_DONE : S_UPD2;
					end else begin
						if (s_rlink != LINK_FREE) rsp_q.status <= ST_CORRUPT;
						state_q <= S_DONE;
					end
				end
				S_UPD2: state_q <= S_FIX;
				S_FIX: state_q <= S_DONE;
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("accept while busy");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[12:11] != 2'd3) else $error("bad status");
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[12:11] == ST_OK) else $error("found with error");
`endif
endmodule

/* design/ichm_head_mem.sv */
// bucket head memory, one read and one write port, cleared by a sweep after reset
module ichm_head_mem (
	input logic clk,
	input logic rd_en,
	input logic [ichm_pkg::BucketW-1:0] rd_addr,
	output logic [ichm_pkg::LinkW-1:0] rd_data,
	input logic wr_en,
	input logic [ichm_pkg::BucketW-1:0] wr_addr,
	input logic [ichm_pkg::LinkW-1:0] wr_data
);
	import ichm_pkg::*;
	logic [LinkW-1:0] mem [NumBuckets];
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data <= mem[rd_addr];
	end
endmodule

/* design/ichm_slot_mem.sv */
// per-slot key and successor memory, one read and one write port
module ichm_slot_mem (
	input logic clk,
	input logic rd_en,
	input logic [ichm_pkg::SlotW-1:0] rd_addr,
	output logic [ichm_pkg::KeyW-1:0] rd_key,
	output logic [ichm_pkg::LinkW-1:0] rd_link,
	input logic wr_en,
	input logic [ichm_pkg::SlotW-1:0] wr_addr,
	input logic [ichm_pkg::KeyW-1:0] wr_key,
	input logic [ichm_pkg::LinkW-1:0] wr_link
);
	import ichm_pkg::*;
	logic [KeyW+LinkW-1:0] mem [NumSlots];
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= {wr_key, wr_link};
		if (rd_en) {rd_key, rd_link} <= mem[rd_addr];
	end
endmodule

/* dv/indexed_chain_hash_map_unit_tb.sv */
// testbench for the indexed chain hash map: table-driven directed words, then random traffic
module indexed_chain_hash_map_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ichm_pkg::*;

	localparam int StallLimit = 20000;

	typedef struct {
		logic [1:0] req_type;
		logic [31:0] space_oid;
		logic [31:0] database_oid;
		logic [31:0] relation_number;
		logic [1:0] fork_number;
		logic [31:0] block_number;
		logic [31:0] hash_code;
		logic [9:0] slot_index;
	} map_req_t;

	typedef struct packed {
		logic found;
		logic [9:0] match_slot;
		logic [1:0] status;
	} map_rsp_t;

	typedef struct {
		map_req_t req;
		bit has_rsp;
		map_rsp_t rsp;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [175:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;

	logic [LinkW-1:0] head_mem [NumBuckets];
	logic [63:0] loc_mem [NumSlots];
	logic [33:0] relfork_mem [NumSlots];
	logic [31:0] blk_mem [NumSlots];
	logic [LinkW-1:0] next_mem [NumSlots];

	map_rsp_t rsp_queue [$];
	map_req_t used_keys [$];
	row_t rows [$];
	int errors = 0;
	int idle_cycles = 0;
	bit hold_sink = 1'b0;
	bit stim_done = 1'b0;

	indexed_chain_hash_map_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic map_rsp_t map_apply(map_req_t r);
		map_rsp_t o;
		logic [63:0] loc;
		logic [33:0] rf;
		logic [BucketW-1:0] bkt;
		logic [LinkW-1:0] cur, prev, hit, hit_prev;
		int steps;
		loc = {r.database_oid, r.space_oid};
		rf = {r.fork_number, r.relation_number};
		bkt = r.hash_code[BucketW-1:0];
		o = '{1'b0, 10'd0, ST_OK};
		if (r.req_type == REQ_INSERT && r.block_number == 32'hFFFF_FFFF) begin
			o.status = ST_REJECT;
			return o;
		end
		cur = head_mem[bkt];
		prev = LINK_END;
		hit = LINK_END;
		hit_prev = LINK_END;
		steps = 0;
		while (cur < NumSlots && steps < NumSlots) begin
			if (loc_mem[cur] == loc && relfork_mem[cur] == rf && blk_mem[cur] == r.block_number) begin
				hit = cur;
				hit_prev = prev;
				break;
			end
			prev = cur;
			cur = next_mem[cur];
			steps++;
		end
		if (hit < NumSlots) begin
			o.found = 1'b1;
			o.match_slot = hit[SlotW-1:0];
			if (r.req_type == REQ_DELETE) begin
				if (hit_prev == LINK_END) head_mem[bkt] = next_mem[hit];
				else next_mem[hit_prev] = next_mem[hit];
				next_mem[hit] = LINK_FREE;
				loc_mem[hit] = '0;
				relfork_mem[hit] = '0;
				blk_mem[hit] = '0;
			end
		end else if (r.req_type == REQ_INSERT) begin
			if (next_mem[r.slot_index] != LINK_FREE) begin
				o.status = ST_CORRUPT;
			end else begin
				loc_mem[r.slot_index] = loc;
				relfork_mem[r.slot_index] = rf;
				blk_mem[r.slot_index] = r.block_number;
				next_mem[r.slot_index] = head_mem[bkt];
				head_mem[bkt] = {2'b00, r.slot_index};
			end
		end else if (r.req_type == REQ_DELETE) begin
			o.status = ST_CORRUPT;
		end
		return o;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic map_req_t rand_req();
		map_req_t r;
		int p;
		p = $urandom_range(0, 99);
		if (used_keys.size() > 0 && p < 60) begin
			r = used_keys[$urandom_range(0, used_keys.size() - 1)];
		end else begin
			r.space_oid = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3);
			r.database_oid = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3);
			r.relation_number = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7);
			r.fork_number = 2'($urandom_range(0, 3));
			r.block_number = ($urandom_range(0, 30) == 0) ? 32'hFFFF_FFFF :
				(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15));
			r.hash_code = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 15);
			if (used_keys.size() < 200) used_keys.push_back(r);
			else used_keys[$urandom_range(0, 199)] = r;
		end
		r.req_type = 2'($urandom_range(0, 3));
		if (r.req_type == 2'd3 && $urandom_range(0, 3) != 0) r.req_type = REQ_INSERT;
		r.slot_index = 10'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 31) : $urandom);
		return r;
	endfunction

	function automatic map_req_t mk(logic [1:0] t, logic [31:0] sp, logic [31:0] db,
			logic [31:0] rel, logic [1:0] fk, logic [31:0] blk, logic [31:0] h,
			logic [9:0] sl);
		map_req_t r;
		r = '{t, sp, db, rel, fk, blk, h, sl};
		return r;
	endfunction

	task automatic send_word(map_req_t r, bit has_rsp, map_rsp_t given);
		map_rsp_t pred;
		s_tdata <= {2'd0, r.slot_index, r.hash_code, r.block_number, r.fork_number,
			r.relation_number, r.database_oid, r.space_oid, r.req_type};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pred = map_apply(r);
		if (has_rsp && pred != given) begin
			$error("table row disagrees with prediction: %p vs %p", given, pred);
			errors++;
		end
		rsp_queue.push_back(has_rsp ? given : pred);
	endtask

	initial begin
		map_rsp_t ok_miss, rej, bad;
		ok_miss = '{1'b0, 10'd0, ST_OK};
		rej = '{1'b0, 10'd0, ST_REJECT};
		bad = '{1'b0, 10'd0, ST_CORRUPT};
		for (int i = 0; i < NumBuckets; i++) head_mem[i] = LINK_END;
		for (int i = 0; i < NumSlots; i++) begin
			loc_mem[i] = '0;
			relfork_mem[i] = '0;
			blk_mem[i] = '0;
			next_mem[i] = LINK_FREE;
		end
		rows = '{
			'{mk(REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0), 1, ok_miss},
			'{mk(REQ_DELETE, 1, 2, 3, 1, 4, 5, 0), 1, bad},
			'{mk(REQ_INSERT, 1, 2, 3, 1, 32'hFFFF_FFFF, 5, 7), 1, rej},
			'{mk(2'd3, 1, 2, 3, 1, 4, 5, 0), 1, ok_miss},
			'{mk(REQ_INSERT, 0, 0, 0, 0, 0, 0, 0), 1, ok_miss},
			'{mk(REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 9), 1, '{1'b1, 10'd0, ST_OK}},
			'{mk(REQ_INSERT, 0, 0, 0, 0, 0, 0, 5), 1, '{1'b1, 10'd0, ST_OK}},
			'{mk(REQ_INSERT, 1, 1, 1, 1, 1, 0, 0), 1, bad},
			'{mk(REQ_INSERT, '1, '1, '1, 3, 32'hFFFF_FFFE, '1, 10'h3FF), 0, ok_miss},
			'{mk(REQ_INSERT, 7, 7, 7, 2, 7, 32'hFFFF_FC00, 1), 0, ok_miss},
			'{mk(REQ_INSERT, 8, 8, 8, 3, 8, 32'h0000_0400, 2), 0, ok_miss},
			'{mk(REQ_INSERT, 9, 9, 9, 0, 9, 0, 3), 0, ok_miss},
			'{mk(REQ_LOOKUP, 7, 7, 7, 2, 7, 0, 0), 0, ok_miss},
			'{mk(REQ_DELETE, 8, 8, 8, 3, 8, 0, 0), 0, ok_miss},
			'{mk(REQ_LOOKUP, 7, 7, 7, 2, 7, 0, 0), 0, ok_miss},
			'{mk(REQ_LOOKUP, 8, 8, 8, 3, 8, 0, 0), 0, ok_miss},
			'{mk(REQ_DELETE, 0, 0, 0, 0, 0, 0, 0), 0, ok_miss},
			'{mk(REQ_INSERT, 4, 4, 4, 1, 4, 0, 2), 0, ok_miss},
			'{mk(REQ_LOOKUP, '1, '1, '1, 3, 32'hFFFF_FFFE, '1, 0), 0, ok_miss},
			'{mk(REQ_LOOKUP, '1, '1, '1, 3, 32'hFFFF_FFFF, '1, 0), 1, ok_miss},
			'{mk(REQ_DELETE, '1, '1, '1, 3, 32'hFFFF_FFFE, '1, 0), 0, ok_miss},
			'{mk(REQ_INSERT, '1, '1, '1, 3, 32'hFFFF_FFFE, '1, 10'h3FF), 0, ok_miss}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		foreach (rows[i]) send_word(rows[i].req, rows[i].has_rsp, rows[i].rsp);
		s_tvalid <= 1'b0;
		wait (rsp_queue.size() == 0);
		@(posedge clk);
		for (int n = 0; n < 1400; n++) begin
			int g;
			if (n == 300) begin
				hold_sink = 1'b1;
			end
			if (n == 700) begin
				s_tvalid <= 1'b0;
				wait (rsp_queue.size() == 0);
				@(posedge clk);
			end
			g = (n >= 300 && n < 340) ? 0 : gap_len();
			if (g > 0) begin
				s_tvalid <= 1'b0;
				repeat (g) @(posedge clk);
			end
			send_word(rand_req(), 0, ok_miss);
		end
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				hold_sink = 1'b0;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			g = gap_len();
			if (g > 0) begin
				m_tready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		map_rsp_t exp_rsp;
		if (arst_n && m_tvalid && m_tready) begin
			if (rsp_queue.size() == 0) begin
				$error("result word with nothing expected: %h", m_tdata);
				errors++;
			end else begin
				exp_rsp = rsp_queue.pop_front();
				if (m_tdata[0] !== exp_rsp.found) begin
					$error("found: expected %0d, got %0d", exp_rsp.found, m_tdata[0]);
					errors++;
				end
				if (m_tdata[10:1] !== exp_rsp.match_slot) begin
					$error("match_slot: expected %0d, got %0d", exp_rsp.match_slot,
						m_tdata[10:1]);
					errors++;
				end
				if (m_tdata[12:11] !== exp_rsp.status) begin
					$error("status: expected %0d, got %0d", exp_rsp.status, m_tdata[12:11]);
					errors++;
				end
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= StallLimit) begin
				$display("indexed_chain_hash_map_unit_tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		wait (stim_done && rsp_queue.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0 && rsp_queue.size() == 0) begin
			$display("indexed_chain_hash_map_unit_tb: done, clean");
		end else begin
			$display("indexed_chain_hash_map_unit_tb: done, errors");
		end
		$finish;
	end
endmodule

/* filelist.f */
design/ichm_pkg.sv
design/ichm_head_mem.sv
design/ichm_slot_mem.sv
design/indexed_chain_hash_map_unit.sv
dv/indexed_chain_hash_map_unit_tb.sv
